// ----- rtl/core/grs_pkg.sv -----
package grs_pkg;

   // width of the group size register
   localparam int CSR_WIDTH = 5;

   // group size after reset
   localparam logic [CSR_WIDTH-1:0] CSR_GROUP_SIZE_RESET = 5'd1;

   // drain sequencer states
   typedef enum logic {
      ST_IDLE,
      ST_DRAIN
   } drain_state_type;

   // hands a buffer bank back to the front once its last read is issued
   typedef struct packed {
      logic valid;
      logic bank;
   } bank_release_type;

endpackage

// ----- rtl/core/grs_front.sv -----
module grs_front #(
   parameter int MAX_GROUP  = 16,
   parameter int DATA_WIDTH = 16,
   parameter int CNT_W      = 5,
   parameter int IDX_W      = 4,
   parameter int JOB_W      = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [grs_pkg::CSR_WIDTH-1:0] csr_group_size,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [DATA_WIDTH-1:0]         req_value,
   input  logic                          req_list_end,
   output logic                          mem_wr_en,
   output logic [IDX_W:0]                mem_wr_addr,
   output logic [DATA_WIDTH-1:0]         mem_wr_data,
   output logic                          job_push,
   output logic [JOB_W-1:0]              job_data,
   input  grs_pkg::bank_release_type     release_bank
);

   typedef struct packed {
      logic             bank;
      logic [CNT_W-1:0] count;
      logic             rev;
      logic             last;
   } job_type;

   logic [grs_pkg::CSR_WIDTH-1:0] group_size_ff;
   logic [CNT_W-1:0]              fill_ff;
   logic [CNT_W-1:0]              fill_in;
   logic                          bank_ff;
   logic                          bank_in;
   logic [1:0]                    busy_ff;
   logic [1:0]                    busy_in;
   logic [CNT_W-1:0]              eff_size;
   logic [CNT_W-1:0]              fill_next;
   logic                          accept;
   logic                          group_done;
   job_type                       job;

   // effective group size: zero acts as one, large values saturate
   always_comb begin
      if (group_size_ff == '0) begin
         eff_size = CNT_W'(1);
      end else if (int'(group_size_ff) > MAX_GROUP) begin
         eff_size = CNT_W'(MAX_GROUP);
      end else begin
         eff_size = CNT_W'(group_size_ff);
      end
   end

   // request classification
   assign req_stall  = busy_ff[bank_ff];
   assign accept     = req_valid & ~req_stall;
   assign fill_next  = fill_ff + CNT_W'(1);
   assign group_done = (fill_next >= eff_size) | req_list_end;

   // buffer write into the bank being filled
   assign mem_wr_en   = accept;
   assign mem_wr_addr = {bank_ff, fill_ff[IDX_W-1:0]};
   assign mem_wr_data = req_value;

   // job descriptor for the drain side
   always_comb begin
      job.bank  = bank_ff;
      job.count = fill_next;
      job.rev   = (fill_next >= eff_size);
      job.last  = req_list_end;
   end

   assign job_push = accept & group_done;
   assign job_data = job;

   // fill and bank tracking
   always_comb begin
      fill_in = fill_ff;
      bank_in = bank_ff;
      busy_in = busy_ff;
      if (accept) begin
         if (group_done) begin
            fill_in          = '0;
            bank_in          = ~bank_ff;
            busy_in[bank_ff] = 1'b1;
         end else begin
            fill_in = fill_next;
         end
      end
      if (release_bank.valid) begin
         busy_in[release_bank.bank] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         group_size_ff <= grs_pkg::CSR_GROUP_SIZE_RESET;
         fill_ff       <= '0;
         bank_ff       <= 1'b0;
         busy_ff       <= '0;
      end else begin
         if (csr_write_enable) begin
            group_size_ff <= csr_group_size;
         end
         fill_ff <= fill_in;
         bank_ff <= bank_in;
         busy_ff <= busy_in;
      end
   end

endmodule

// ----- rtl/core/grs_queue.sv -----
module grs_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] head
);

   logic [WIDTH-1:0] slot_ff [2];
   logic             wr_ptr_ff;
   logic             rd_ptr_ff;
   logic [1:0]       count_ff;
   logic [1:0]       count_in;

   assign empty = (count_ff == 2'd0);
   assign head  = slot_ff[rd_ptr_ff];

   // occupancy
   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/core/grs_back.sv -----
module grs_back #(
   parameter int DATA_WIDTH = 16,
   parameter int CNT_W      = 5,
   parameter int IDX_W      = 4,
   parameter int JOB_W      = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      mem_wr_en,
   input  logic [IDX_W:0]            mem_wr_addr,
   input  logic [DATA_WIDTH-1:0]     mem_wr_data,
   input  logic                      job_empty,
   input  logic [JOB_W-1:0]          job_head,
   output logic                      job_pop,
   output grs_pkg::bank_release_type release_bank,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [DATA_WIDTH-1:0]     rsp_out_value,
   output logic                      rsp_run_last,
   output logic                      rsp_out_list_end
);

   localparam int MEM_DEPTH = 2 ** (IDX_W + 1);

   typedef struct packed {
      logic             bank;
      logic [CNT_W-1:0] count;
      logic             rev;
      logic             last;
   } job_type;

   logic [DATA_WIDTH-1:0]     mem [MEM_DEPTH];
   grs_pkg::drain_state_type  state_ff;
   grs_pkg::drain_state_type  state_in;
   job_type                   job_ff;
   job_type                   job_in;
   logic [CNT_W-1:0]          idx_ff;
   logic [CNT_W-1:0]          idx_in;
   logic [CNT_W-1:0]          rd_idx;
   logic [IDX_W:0]            rd_addr;
   logic                      final_el;
   logic                      issue;
   logic                      load;
   logic                      out_free;
   logic                      s1_move;
   logic                      s1_free;
   logic                      s1_valid_ff;
   logic                      s1_last_ff;
   logic                      s1_end_ff;
   logic [DATA_WIDTH-1:0]     mem_q_ff;
   logic                      rsp_valid_ff;
   logic [DATA_WIDTH-1:0]     rsp_value_ff;
   logic                      rsp_run_last_ff;
   logic                      rsp_end_ff;

   // pipeline flow: read issue -> read data stage -> output register
   assign out_free = ~rsp_valid_ff | ~rsp_stall;
   assign s1_move  = s1_valid_ff & out_free;
   assign s1_free  = ~s1_valid_ff | s1_move;
   assign issue    = (state_ff == grs_pkg::ST_DRAIN) & s1_free;
   assign final_el = (idx_ff + CNT_W'(1)) == job_ff.count;
   assign load     = ((state_ff == grs_pkg::ST_IDLE) | (issue & final_el)) & ~job_empty;

   // read address: reversed or in arrival order
   assign rd_idx  = job_ff.rev ? (job_ff.count - CNT_W'(1) - idx_ff) : idx_ff;
   assign rd_addr = {job_ff.bank, rd_idx[IDX_W-1:0]};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         grs_pkg::ST_IDLE: begin
            if (!job_empty) begin
               state_in = grs_pkg::ST_DRAIN;
            end
         end
         grs_pkg::ST_DRAIN: begin
            if (issue && final_el && job_empty) begin
               state_in = grs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = grs_pkg::ST_IDLE;
         end
      endcase
   end

   // sequencer outputs
   always_comb begin
      job_pop            = load;
      release_bank.valid = issue & final_el;
      release_bank.bank  = job_ff.bank;
      job_in             = job_ff;
      idx_in             = idx_ff;
      if (load) begin
         job_in = job_type'(job_head);
         idx_in = '0;
      end else if (issue) begin
         idx_in = idx_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= grs_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      idx_ff <= idx_in;
   end

   // ping-pong group buffer
   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         mem[mem_wr_addr] <= mem_wr_data;
      end
      if (issue) begin
         mem_q_ff <= mem[rd_addr];
      end
   end

   // read data stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (issue) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_move) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         s1_last_ff <= final_el;
         s1_end_ff  <= final_el & job_ff.last;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_value_ff    <= mem_q_ff;
         rsp_run_last_ff <= s1_last_ff;
         rsp_end_ff      <= s1_end_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_value    = rsp_value_ff;
   assign rsp_run_last     = rsp_run_last_ff;
   assign rsp_out_list_end = rsp_end_ff;

endmodule

// ----- rtl/core/group_reverse_stream.sv -----
// channel  | ports                                          | direction
// ---------+------------------------------------------------+----------
// request  | req_valid, req_stall, req_value, req_list_end  | in
// response | rsp_valid, rsp_stall, rsp_out_value,           | out
//          | rsp_run_last, rsp_out_list_end                 |
// csr      | csr_write_enable, csr_group_size               | in
//
// One request per cycle is taken while the buffer bank being filled is free;
// one response per cycle leaves the output register while rsp_stall is low.
// A group's first response passes the job queue, job register, read data stage and output register.
// Two buffer banks alternate: req_stall rises when both hold groups still draining.
// Reset (synchronous) empties the queue and pipeline and sets group size to one.
module group_reverse_stream #(
   parameter int MAX_GROUP  = 16,
   parameter int DATA_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [grs_pkg::CSR_WIDTH-1:0] csr_group_size,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [DATA_WIDTH-1:0]         req_value,
   input  logic                          req_list_end,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [DATA_WIDTH-1:0]         rsp_out_value,
   output logic                          rsp_run_last,
   output logic                          rsp_out_list_end
);

   localparam int CNT_W = $clog2(MAX_GROUP + 1);
   localparam int IDX_W = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
   localparam int JOB_W = CNT_W + 3;

   logic                      mem_wr_en;
   logic [IDX_W:0]            mem_wr_addr;
   logic [DATA_WIDTH-1:0]     mem_wr_data;
   logic                      job_push;
   logic [JOB_W-1:0]          job_data;
   logic                      job_pop;
   logic                      job_empty;
   logic [JOB_W-1:0]          job_head;
   grs_pkg::bank_release_type release_bank;

   // request side: store values, cut groups
   grs_front #(
      .MAX_GROUP  (MAX_GROUP),
      .DATA_WIDTH (DATA_WIDTH),
      .CNT_W      (CNT_W),
      .IDX_W      (IDX_W),
      .JOB_W      (JOB_W)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_group_size   (csr_group_size),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_value        (req_value),
      .req_list_end     (req_list_end),
      .mem_wr_en        (mem_wr_en),
      .mem_wr_addr      (mem_wr_addr),
      .mem_wr_data      (mem_wr_data),
      .job_push         (job_push),
      .job_data         (job_data),
      .release_bank     (release_bank)
   );

   // group descriptors waiting to drain
   grs_queue #(
      .WIDTH (JOB_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_data),
      .pop       (job_pop),
      .empty     (job_empty),
      .head      (job_head)
   );

   // response side: read groups out of the buffer
   grs_back #(
      .DATA_WIDTH (DATA_WIDTH),
      .CNT_W      (CNT_W),
      .IDX_W      (IDX_W),
      .JOB_W      (JOB_W)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .mem_wr_en        (mem_wr_en),
      .mem_wr_addr      (mem_wr_addr),
      .mem_wr_data      (mem_wr_data),
      .job_empty        (job_empty),
      .job_head         (job_head),
      .job_pop          (job_pop),
      .release_bank     (release_bank),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_value    (rsp_out_value),
      .rsp_run_last     (rsp_run_last),
      .rsp_out_list_end (rsp_out_list_end)
   );

endmodule
